// ===== rtl/assert_macros.svh =====
// assertion macros included by the tokenizer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: assertion failed");

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/utf8cf_pkg.sv =====
// types, constants and the case fold function of the utf-8 case fold tokenizer
package utf8cf_pkg;

    localparam int CODE_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int SEP_CNT_W   = 4;
    localparam int SLOTS_PER_REG = 4;
    localparam int MAX_ENC     = 3;
    localparam int FIFO_DEPTH  = 16;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;
    localparam int FIFO_RDY_MAX = FIFO_DEPTH - 2 * MAX_ENC;

    typedef logic [CODE_W-1:0] t_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEP_LOW   = 2'd0,
        CFG_SEP_HIGH  = 2'd1,
        CFG_SEP_COUNT = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              token_start;
        logic              char_last;
    } t_out_word;

    function automatic t_code fold_case(input t_code cp);
        t_code res;
        res = cp;
        if (cp >= 16'h0041 && cp <= 16'h005A) begin
            res = cp + 16'h0020;
        end else begin
            case (cp)
                16'h00C0: res = 16'h00E0;
                16'h1EA2: res = 16'h1EA3;
                16'h00C3: res = 16'h00E3;
                16'h00C1: res = 16'h00E1;
                16'h1EA0: res = 16'h1EA1;
                16'h1EB0: res = 16'h1EB1;
                16'h1EB2: res = 16'h1EB3;
                16'h1EB4: res = 16'h1EB5;
                16'h1EAE: res = 16'h1EAF;
                16'h1EB6: res = 16'h1EB7;
                16'h0102: res = 16'h0103;
                16'h1EA6: res = 16'h1EA7;
                16'h1EA8: res = 16'h1EA9;
                16'h1EAA: res = 16'h1EAB;
                16'h1EA4: res = 16'h1EA5;
                16'h1EAC: res = 16'h1EAD;
                16'h00C2: res = 16'h00E2;
                16'h00C8: res = 16'h00E8;
                16'h1EBA: res = 16'h1EBB;
                16'h1EBC: res = 16'h1EBD;
                16'h00C9: res = 16'h00E9;
                16'h1EB8: res = 16'h1EB9;
                16'h1EC0: res = 16'h1EC1;
                16'h1EC2: res = 16'h1EC3;
                16'h1EC4: res = 16'h1EC5;
                16'h1EBE: res = 16'h1EBF;
                16'h1EC6: res = 16'h1EC7;
                16'h00CA: res = 16'h00EA;
                16'h00CC: res = 16'h00EC;
                16'h1EC8: res = 16'h1EC9;
                16'h0128: res = 16'h0129;
                16'h00CD: res = 16'h00ED;
                16'h1ECA: res = 16'h1ECB;
                16'h00D2: res = 16'h00F2;
                16'h1ECE: res = 16'h1ECF;
                16'h00D5: res = 16'h00F5;
                16'h00D3: res = 16'h00F3;
                16'h1ECC: res = 16'h1ECD;
                16'h1ED2: res = 16'h1ED3;
                16'h1ED4: res = 16'h1ED5;
                16'h1ED6: res = 16'h1ED7;
                16'h1ED0: res = 16'h1ED1;
                16'h1ED8: res = 16'h1ED9;
                16'h00D4: res = 16'h00F4;
                16'h1EDC: res = 16'h1EDD;
                16'h1EDE: res = 16'h1EDF;
                16'h1EE0: res = 16'h1EE1;
                16'h1EDA: res = 16'h1EDB;
                16'h1EE2: res = 16'h1EE3;
                16'h01A0: res = 16'h01A1;
                16'h00D9: res = 16'h00F9;
                16'h1EE6: res = 16'h1EE7;
                16'h0168: res = 16'h0169;
                16'h00DA: res = 16'h00FA;
                16'h1EE4: res = 16'h1EE5;
                16'h1EEA: res = 16'h1EEB;
                16'h1EEC: res = 16'h1EED;
                16'h1EEE: res = 16'h1EEF;
                16'h1EE8: res = 16'h1EE9;
                16'h1EF0: res = 16'h1EF1;
                16'h01AF: res = 16'h01B0;
                16'h1EF2: res = 16'h1EF3;
                16'h1EF6: res = 16'h1EF7;
                16'h1EF8: res = 16'h1EF9;
                16'h00DD: res = 16'h00FD;
                16'h1EF4: res = 16'h1EF5;
                16'h0110: res = 16'h0111;
                default:  res = cp;
            endcase
        end
        return res;
    endfunction

endpackage

// ===== rtl/utf8cf_if.sv =====
// channel interfaces of the utf-8 case fold tokenizer
interface utf8cf_in_if import utf8cf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              first_of_string;

    modport source (output valid, output text_byte, output first_of_string, input ready);
    modport sink (input valid, input text_byte, input first_of_string, output ready);
endinterface

interface utf8cf_out_if import utf8cf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] encoded_byte;
    logic              token_start;
    logic              char_last;

    modport source (output valid, output encoded_byte, output token_start,
                    output char_last, input ready);
    modport sink (input valid, input encoded_byte, input token_start,
                  input char_last, output ready);
endinterface

interface utf8cf_cfg_if import utf8cf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/utf8_case_fold_tokenizer_unit.sv =====
// utf-8 case fold tokenizer: decode, fold, separator match, re-encode, byte queue
// an accepted input word is held in the input register, and the encoded words of
// the character that it completes are written from there into the output word queue
// throughput: one input word per cycle; input stalls while more than 10 words
// wait in the 16-entry output word queue, which drains one word per cycle while o_out.ready is high
// reset clears decoder state, token state, separators and the queue
`include "assert_macros.svh"

module utf8_case_fold_tokenizer_unit import utf8cf_pkg::*; #(
    parameter int SEPARATOR_SLOTS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8cf_in_if.sink     i_in,
    utf8cf_out_if.source  o_out,
    utf8cf_cfg_if.sink    i_cfg
);

    // configuration
    t_code                r_sep [SEPARATOR_SLOTS];
    logic [SEP_CNT_W-1:0] r_sep_count;
    logic                 cfg_fire;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;
    logic              in_fire;

    // decoder and token state
    t_code r_partial;
    logic [1:0] r_pend;
    logic  r_inword;
    t_code n_partial;
    logic [1:0] n_pend;
    logic  n_inword;
    t_code cur_partial;
    logic [1:0] cur_pend;
    logic  cur_inword;
    logic  char_done;
    t_code cp_raw;
    t_code cp_fold;
    logic [SEPARATOR_SLOTS-1:0] sep_hit;
    logic  is_sep;
    logic  tok_start;
    logic [1:0] enc_len;
    t_out_word enc_word [MAX_ENC];

    // output word queue
    t_out_word             r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [1:0]            n_push;
    logic                  pop;
    t_out_word             head;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_count <= '0;
            for (int k = 0; k < SEPARATOR_SLOTS; k++) begin
                r_sep[k] <= '0;
            end
        end else if (cfg_fire) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_SEP_LOW: begin
                    for (int k = 0; k < SEPARATOR_SLOTS; k++) begin
                        if (k < SLOTS_PER_REG) begin
                            r_sep[k] <= i_cfg.data[CODE_W*(k & 3) +: CODE_W];
                        end
                    end
                end
                CFG_SEP_HIGH: begin
                    for (int k = 0; k < SEPARATOR_SLOTS; k++) begin
                        if (k >= SLOTS_PER_REG) begin
                            r_sep[k] <= i_cfg.data[CODE_W*(k & 3) +: CODE_W];
                        end
                    end
                end
                CFG_SEP_COUNT: begin
                    r_sep_count <= i_cfg.data[SEP_CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // room for the word in the input register and one more
    assign i_in.ready = (r_count <= FIFO_CNT_W'(FIFO_RDY_MAX));
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte  <= i_in.text_byte;
            r_in_first <= i_in.first_of_string;
        end
    end

    // utf-8 decode
    always_comb begin
        cur_partial = r_in_first ? '0 : r_partial;
        cur_pend    = r_in_first ? 2'd0 : r_pend;
        cur_inword  = r_in_first ? 1'b0 : r_inword;
        n_partial   = cur_partial;
        n_pend      = cur_pend;
        char_done   = 1'b0;
        cp_raw      = '0;
        if (cur_pend == 2'd2) begin
            n_partial = cur_partial | {4'd0, r_in_byte[5:0], 6'd0};
            n_pend    = 2'd1;
        end else if (cur_pend == 2'd1) begin
            cp_raw    = cur_partial | {10'd0, r_in_byte[5:0]};
            char_done = 1'b1;
            n_partial = '0;
            n_pend    = 2'd0;
        end else if (r_in_byte[7:5] == 3'b111) begin
            n_partial = {r_in_byte[3:0], 12'd0};
            n_pend    = 2'd2;
        end else if (r_in_byte[7:6] == 2'b11) begin
            n_partial = {5'd0, r_in_byte[4:0], 6'd0};
            n_pend    = 2'd1;
        end else if (!r_in_byte[7]) begin
            cp_raw    = {8'd0, r_in_byte};
            char_done = 1'b1;
        end
    end

    assign cp_fold = fold_case(cp_raw);

    always_comb begin
        for (int k = 0; k < SEPARATOR_SLOTS; k++) begin
            sep_hit[k] = (r_sep[k] == cp_fold) && (SEP_CNT_W'(k) < r_sep_count);
        end
    end

    assign is_sep = |sep_hit;

    // token marking and re-encode
    always_comb begin
        n_inword  = cur_inword;
        tok_start = 1'b0;
        if (char_done) begin
            tok_start = is_sep || !cur_inword;
            n_inword  = !is_sep;
        end
        for (int i = 0; i < MAX_ENC; i++) begin
            enc_word[i] = '0;
        end
        if (cp_fold < 16'h0080) begin
            enc_len     = 2'd1;
            enc_word[0] = '{data: cp_fold[7:0], token_start: tok_start, char_last: 1'b1};
        end else if (cp_fold < 16'h0800) begin
            enc_len     = 2'd2;
            enc_word[0] = '{data: {3'b110, cp_fold[10:6]}, token_start: tok_start,
                            char_last: 1'b0};
            enc_word[1] = '{data: {2'b10, cp_fold[5:0]}, token_start: 1'b0,
                            char_last: 1'b1};
        end else begin
            enc_len     = 2'd3;
            enc_word[0] = '{data: {4'b1110, cp_fold[15:12]}, token_start: tok_start,
                            char_last: 1'b0};
            enc_word[1] = '{data: {2'b10, cp_fold[11:6]}, token_start: 1'b0,
                            char_last: 1'b0};
            enc_word[2] = '{data: {2'b10, cp_fold[5:0]}, token_start: 1'b0,
                            char_last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pend    <= 2'd0;
            r_inword  <= 1'b0;
        end else if (r_in_valid) begin
            r_partial <= n_partial;
            r_pend    <= n_pend;
            r_inword  <= n_inword;
        end
    end

    // output word queue
    assign n_push = (r_in_valid && char_done) ? enc_len : 2'd0;
    assign head   = r_fifo[r_rd];
    assign pop    = o_out.valid && o_out.ready;

    assign o_out.valid        = (r_count != '0);
    assign o_out.encoded_byte = head.data;
    assign o_out.token_start  = head.token_start;
    assign o_out.char_last    = head.char_last;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENC; i++) begin
            if (2'(i) < n_push) begin
                r_fifo[r_wr + FIFO_PTR_W'(i)] <= enc_word[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_PTR_W'(n_push);
            r_rd    <= r_rd + FIFO_PTR_W'(pop);
            r_count <= r_count + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
        end
    end

    `ASSERT_NEVER(a_fifo_no_overflow, i_clk, i_rst_n, r_count > FIFO_CNT_W'(FIFO_DEPTH))
    `ASSERT_NEVER(a_pend_legal, i_clk, i_rst_n, r_pend == 2'd3)
    `ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, pop && n_push == 2'd0, r_count == $past(r_count) - 1'b1)
    `ASSERT_NEXT(a_three_byte_mid, i_clk, i_rst_n, r_in_valid && !r_in_first && r_pend == 2'd2, r_pend == 2'd1)

endmodule
